// File: rtl/fbpm_pkg.sv
// ----------------------------------------------------------------------------
// fbpm_pkg
// Shared types and constants of the frame buffer pool manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpm_pkg;

   localparam int NumFramesDefault  = 8;
   localparam int NumHandlesDefault = 16;
   localparam int MaxLocksDefault   = 255;

   typedef enum logic [2:0] {
      CMD_ACQUIRE          = 3'd0,
      CMD_ACQUIRE_RENDERED = 3'd1,
      CMD_RELEASE          = 3'd2,
      CMD_MARK_RENDERED    = 3'd3,
      CMD_QUERY            = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NONE         = 2'd1,
      STATUS_NOT_RENDERED = 2'd2,
      STATUS_MISUSE       = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FRAME_FREE     = 2'd0,
      FRAME_LOCKED   = 2'd1,
      FRAME_RENDERED = 2'd2,
      FRAME_FREEABLE = 2'd3
   } frame_state_type;

endpackage

`default_nettype wire

// File: rtl/frame_buffer_pool_manager_core.sv
// ----------------------------------------------------------------------------
// frame_buffer_pool_manager_core
// Reference-counted pool of frame buffers shared by picture handles.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_ready, req_command, req_handle_id)
// takes one command transaction at a time. Each command returns exactly one
// response transaction on the rsp_ channel with a status, the handle's frame
// binding, the frame state, the lock count and any reclaimed handle.
// A small sequencer reads the handle tables, then the frame tables, then the
// owner of the oldest freeable frame, and then applies the command. When a
// frame is reclaimed from another handle, a further state unbinds that
// handle. Taking a frame off the freeable list compacts that list one entry
// per cycle before the response is loaded. A handle out of range skips the
// table reads and goes straight to the response with a misuse status.
// The block is not ready for a new request until the response of the
// current one has been loaded into the output register.
// Synchronous reset frees all frames, fills the free queue in frame order,
// empties the freeable list and unbinds every handle. When the receiver
// stalls, the response register holds its transaction and the sequencer
// waits before loading the next response.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_buffer_pool_manager_core #(
   parameter int POOL_FRAMES = fbpm_pkg::NumFramesDefault,
   parameter int NUM_HANDLES = fbpm_pkg::NumHandlesDefault,
   parameter int MAX_LOCKS   = fbpm_pkg::MaxLocksDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_command,
   input  wire logic [3:0] req_handle_id,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_status,
   output logic [2:0]      rsp_frame_id,
   output logic            rsp_has_frame,
   output logic [1:0]      rsp_frame_state,
   output logic [7:0]      rsp_lock_count,
   output logic            rsp_evicted_valid,
   output logic [3:0]      rsp_evicted_handle
);

   localparam int FW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
   localparam int HW = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
   localparam int CW = $clog2(POOL_FRAMES + 1);
   localparam int LW = $clog2(MAX_LOCKS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_READ_HANDLE, S_READ_FRAME, S_READ_OWNER,
      S_EXEC, S_EVICT, S_DROP, S_OUT
   } seq_state_type;

   seq_state_type   state_ff;
   logic [2:0]      cmd_ff;
   logic [HW-1:0]   h_ff;
   logic            b_ff;
   logic [FW-1:0]   f_ff;
   logic [LW-1:0]   l_ff;
   fbpm_pkg::frame_state_type st_ff;
   logic [FW-1:0]   nf_free_ff;
   logic [FW-1:0]   old_fr_ff;
   logic [HW-1:0]   old_own_ff;
   logic [FW-1:0]   drop_f_ff;
   logic [CW-1:0]   di_ff;
   logic [CW-1:0]   dj_ff;

   fbpm_pkg::frame_state_type frame_status_ff [POOL_FRAMES];
   logic [HW-1:0]   frame_owner_ff [POOL_FRAMES];
   logic [FW-1:0]   free_queue_ff [POOL_FRAMES];
   logic [FW-1:0]   freeable_list_ff [POOL_FRAMES];
   logic            handle_bound_ff [NUM_HANDLES];
   logic [FW-1:0]   handle_frame_ff [NUM_HANDLES];
   logic [LW-1:0]   handle_locks_ff [NUM_HANDLES];
   logic [FW-1:0]   free_head_ff;
   logic [CW-1:0]   free_count_ff;
   logic [CW-1:0]   freeable_count_ff;

   logic [1:0]      res_status_ff;
   logic [2:0]      res_frame_id_ff;
   logic            res_has_frame_ff;
   logic [1:0]      res_frame_state_ff;
   logic [7:0]      res_lock_count_ff;
   logic            res_ev_valid_ff;
   logic [3:0]      res_ev_handle_ff;

   logic            rsp_valid_ff;
   logic [1:0]      rsp_status_ff;
   logic [2:0]      rsp_frame_id_ff;
   logic            rsp_has_frame_ff;
   logic [1:0]      rsp_frame_state_ff;
   logic [7:0]      rsp_lock_count_ff;
   logic            rsp_ev_valid_ff;
   logic [3:0]      rsp_ev_handle_ff;

   // Decisions of the execute cycle.
   fbpm_pkg::status_type      ex_status;
   logic                      ex_b;
   logic [FW-1:0]             ex_f;
   fbpm_pkg::frame_state_type ex_st;
   logic [LW-1:0]             ex_l;
   logic                      ex_fs_we;
   logic [FW-1:0]             ex_fs_idx;
   fbpm_pkg::frame_state_type ex_fs_val;
   logic                      ex_bind;
   logic                      ex_pop_free;
   logic                      ex_push_free;
   logic                      ex_push_freeable;
   logic                      ex_drop;
   logic                      ex_evict;
   fbpm_pkg::frame_state_type st_eff;
   logic [FW:0]               tail_sum;
   logic [FW-1:0]             tail_idx;
   logic [FW-1:0]             head_next;
   logic                      h_in_range;
   logic                      out_free;

   assign h_in_range = 32'(req_handle_id) < NUM_HANDLES;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign st_eff     = b_ff ? st_ff : fbpm_pkg::FRAME_FREE;
   assign tail_sum   = (FW + 1)'(free_head_ff) + (FW + 1)'(free_count_ff);
   assign tail_idx   = (32'(tail_sum) >= POOL_FRAMES) ?
                       FW'(32'(tail_sum) - POOL_FRAMES) : tail_sum[FW-1:0];
   assign head_next  = (32'(free_head_ff) == POOL_FRAMES - 1) ?
                       '0 : FW'(32'(free_head_ff) + 1);

   always_comb begin
      ex_status        = fbpm_pkg::STATUS_OK;
      ex_b             = b_ff;
      ex_f             = f_ff;
      ex_st            = st_eff;
      ex_l             = l_ff;
      ex_fs_we         = 1'b0;
      ex_fs_idx        = f_ff;
      ex_fs_val        = st_eff;
      ex_bind          = 1'b0;
      ex_pop_free      = 1'b0;
      ex_push_free     = 1'b0;
      ex_push_freeable = 1'b0;
      ex_drop          = 1'b0;
      ex_evict         = 1'b0;
      case (cmd_ff)
         fbpm_pkg::CMD_ACQUIRE, fbpm_pkg::CMD_ACQUIRE_RENDERED: begin
            if (!b_ff) begin
               if (cmd_ff == fbpm_pkg::CMD_ACQUIRE_RENDERED) begin
                  ex_status = fbpm_pkg::STATUS_NOT_RENDERED;
               end else if (free_count_ff != '0) begin
                  ex_bind     = 1'b1;
                  ex_pop_free = 1'b1;
                  ex_fs_idx   = nf_free_ff;
               end else if (freeable_count_ff != '0) begin
                  ex_bind   = 1'b1;
                  ex_drop   = 1'b1;
                  ex_evict  = 1'b1;
                  ex_fs_idx = old_fr_ff;
               end else begin
                  ex_status = fbpm_pkg::STATUS_NONE;
               end
               if (ex_bind) begin
                  ex_fs_we  = 1'b1;
                  ex_fs_val = fbpm_pkg::FRAME_LOCKED;
                  ex_b      = 1'b1;
                  ex_f      = ex_fs_idx;
                  ex_st     = fbpm_pkg::FRAME_LOCKED;
                  ex_l      = LW'(1);
               end
            end else if (l_ff == '0) begin
               if (st_eff == fbpm_pkg::FRAME_FREEABLE) begin
                  ex_drop   = 1'b1;
                  ex_fs_we  = 1'b1;
                  ex_fs_val = fbpm_pkg::FRAME_RENDERED;
                  ex_st     = fbpm_pkg::FRAME_RENDERED;
                  ex_l      = LW'(1);
               end else begin
                  ex_status = fbpm_pkg::STATUS_MISUSE;
               end
            end else if (cmd_ff == fbpm_pkg::CMD_ACQUIRE_RENDERED &&
                         st_eff != fbpm_pkg::FRAME_RENDERED) begin
               ex_status = fbpm_pkg::STATUS_NOT_RENDERED;
            end else if (32'(l_ff) >= MAX_LOCKS) begin
               ex_status = fbpm_pkg::STATUS_MISUSE;
            end else begin
               ex_l = LW'(32'(l_ff) + 1);
            end
         end
         fbpm_pkg::CMD_RELEASE: begin
            if (!b_ff || l_ff == '0) begin
               ex_status = fbpm_pkg::STATUS_MISUSE;
            end else if (32'(l_ff) > 1) begin
               ex_l = LW'(32'(l_ff) - 1);
            end else if (st_eff == fbpm_pkg::FRAME_RENDERED) begin
               ex_l             = '0;
               ex_fs_we         = 1'b1;
               ex_fs_val        = fbpm_pkg::FRAME_FREEABLE;
               ex_st            = fbpm_pkg::FRAME_FREEABLE;
               ex_push_freeable = 1'b1;
            end else if (st_eff == fbpm_pkg::FRAME_LOCKED) begin
               ex_l         = '0;
               ex_fs_we     = 1'b1;
               ex_fs_val    = fbpm_pkg::FRAME_FREE;
               ex_b         = 1'b0;
               ex_push_free = 1'b1;
            end else begin
               ex_status = fbpm_pkg::STATUS_MISUSE;
            end
         end
         fbpm_pkg::CMD_MARK_RENDERED: begin
            if (b_ff && st_eff == fbpm_pkg::FRAME_LOCKED) begin
               ex_fs_we  = 1'b1;
               ex_fs_val = fbpm_pkg::FRAME_RENDERED;
               ex_st     = fbpm_pkg::FRAME_RENDERED;
            end else begin
               ex_status = fbpm_pkg::STATUS_MISUSE;
            end
         end
         fbpm_pkg::CMD_QUERY: begin
            if (!(b_ff && st_eff == fbpm_pkg::FRAME_RENDERED)) begin
               ex_status = fbpm_pkg::STATUS_NOT_RENDERED;
            end
         end
         default: begin
            ex_status = fbpm_pkg::STATUS_MISUSE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         free_head_ff      <= '0;
         free_count_ff     <= CW'(POOL_FRAMES);
         freeable_count_ff <= '0;
         for (int i = 0; i < POOL_FRAMES; i++) begin
            frame_status_ff[i] <= fbpm_pkg::FRAME_FREE;
            free_queue_ff[i]   <= FW'(i);
         end
         for (int i = 0; i < NUM_HANDLES; i++) begin
            handle_bound_ff[i] <= 1'b0;
            handle_locks_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff <= req_command;
                  h_ff   <= HW'(req_handle_id);
                  if (h_in_range) begin
                     state_ff <= S_READ_HANDLE;
                  end else begin
                     res_status_ff      <= fbpm_pkg::STATUS_MISUSE;
                     res_frame_id_ff    <= '0;
                     res_has_frame_ff   <= 1'b0;
                     res_frame_state_ff <= '0;
                     res_lock_count_ff  <= '0;
                     res_ev_valid_ff    <= 1'b0;
                     res_ev_handle_ff   <= '0;
                     state_ff           <= S_OUT;
                  end
               end
            end
            S_READ_HANDLE: begin
               b_ff     <= handle_bound_ff[h_ff];
               f_ff     <= handle_frame_ff[h_ff];
               l_ff     <= handle_locks_ff[h_ff];
               state_ff <= S_READ_FRAME;
            end
            S_READ_FRAME: begin
               st_ff      <= frame_status_ff[f_ff];
               nf_free_ff <= free_queue_ff[free_head_ff];
               old_fr_ff  <= freeable_list_ff[0];
               state_ff   <= S_READ_OWNER;
            end
            S_READ_OWNER: begin
               old_own_ff <= frame_owner_ff[old_fr_ff];
               state_ff   <= S_EXEC;
            end
            S_EXEC: begin
               if (ex_fs_we) begin
                  frame_status_ff[ex_fs_idx] <= ex_fs_val;
               end
               handle_bound_ff[h_ff] <= ex_b;
               handle_locks_ff[h_ff] <= ex_l;
               if (ex_bind) begin
                  frame_owner_ff[ex_fs_idx] <= h_ff;
                  handle_frame_ff[h_ff]     <= ex_fs_idx;
               end
               if (ex_pop_free) begin
                  free_head_ff  <= head_next;
                  free_count_ff <= free_count_ff - 1'b1;
               end
               if (ex_push_free && 32'(free_count_ff) < POOL_FRAMES) begin
                  free_queue_ff[tail_idx] <= f_ff;
                  free_count_ff           <= free_count_ff + 1'b1;
               end
               if (ex_push_freeable && 32'(freeable_count_ff) < POOL_FRAMES) begin
                  freeable_list_ff[freeable_count_ff[FW-1:0]] <= f_ff;
                  freeable_count_ff <= freeable_count_ff + 1'b1;
               end
               drop_f_ff          <= ex_fs_idx;
               di_ff              <= '0;
               dj_ff              <= '0;
               res_status_ff      <= ex_status;
               res_frame_id_ff    <= ex_b ? 3'(ex_f) : 3'd0;
               res_has_frame_ff   <= ex_b;
               res_frame_state_ff <= ex_b ? ex_st : fbpm_pkg::FRAME_FREE;
               res_lock_count_ff  <= 8'(ex_l);
               res_ev_valid_ff    <= ex_evict;
               res_ev_handle_ff   <= ex_evict ? 4'(old_own_ff) : 4'd0;
               if (ex_evict) begin
                  state_ff <= S_EVICT;
               end else if (ex_drop) begin
                  state_ff <= S_DROP;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_EVICT: begin
               handle_bound_ff[old_own_ff] <= 1'b0;
               handle_locks_ff[old_own_ff] <= '0;
               state_ff                    <= S_DROP;
            end
            S_DROP: begin
               if (di_ff < freeable_count_ff) begin
                  if (freeable_list_ff[di_ff[FW-1:0]] != drop_f_ff) begin
                     freeable_list_ff[dj_ff[FW-1:0]] <= freeable_list_ff[di_ff[FW-1:0]];
                     dj_ff <= dj_ff + 1'b1;
                  end
                  di_ff <= di_ff + 1'b1;
               end else begin
                  freeable_count_ff <= dj_ff;
                  state_ff          <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_status_ff      <= res_status_ff;
                  rsp_frame_id_ff    <= res_frame_id_ff;
                  rsp_has_frame_ff   <= res_has_frame_ff;
                  rsp_frame_state_ff <= res_frame_state_ff;
                  rsp_lock_count_ff  <= res_lock_count_ff;
                  rsp_ev_valid_ff    <= res_ev_valid_ff;
                  rsp_ev_handle_ff   <= res_ev_handle_ff;
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_frame_id       = rsp_frame_id_ff;
   assign rsp_has_frame      = rsp_has_frame_ff;
   assign rsp_frame_state    = rsp_frame_state_ff;
   assign rsp_lock_count     = rsp_lock_count_ff;
   assign rsp_evicted_valid  = rsp_ev_valid_ff;
   assign rsp_evicted_handle = rsp_ev_handle_ff;

`ifndef SYNTHESIS
   // Frames are never counted in both the free queue and the freeable list.
   assert property (@(posedge clock) disable iff (reset)
      32'(free_count_ff) + 32'(freeable_count_ff) <= POOL_FRAMES)
      else $error("free and freeable counts exceed the pool size");

   // A reclamation only happens on a successful acquire.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ev_valid_ff |-> rsp_status_ff == fbpm_pkg::STATUS_OK)
      else $error("reclamation reported with a failing status");

   // A handle without a frame reports neither a frame nor a state.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_has_frame_ff |->
         rsp_frame_id_ff == 3'd0 && rsp_frame_state_ff == fbpm_pkg::FRAME_FREE)
      else $error("unbound handle reports frame data");

   // Reclamation only happens when the free queue is empty.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC && ex_evict |-> free_count_ff == '0)
      else $error("reclaimed a frame while free frames remain");
`endif

endmodule

`default_nettype wire

// File: dv/fbpm_checker.sv
// ----------------------------------------------------------------------------
// fbpm_checker
// Watches both channels of the frame buffer pool manager, tracks the pool
// state, and checks every response against the expected transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpm_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [2:0] req_command,
   input  wire logic [3:0] req_handle_id,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [1:0] rsp_status,
   input  wire logic [2:0] rsp_frame_id,
   input  wire logic       rsp_has_frame,
   input  wire logic [1:0] rsp_frame_state,
   input  wire logic [7:0] rsp_lock_count,
   input  wire logic       rsp_evicted_valid,
   input  wire logic [3:0] rsp_evicted_handle,
   output int              failures,
   output int              pending,
   output int              checked,
   output int              evictions
);

   localparam int Frames  = fbpm_pkg::NumFramesDefault;
   localparam int Handles = fbpm_pkg::NumHandlesDefault;
   localparam int MaxLock = fbpm_pkg::MaxLocksDefault;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] frame_id;
      logic       has_frame;
      logic [1:0] frame_state;
      logic [7:0] lock_count;
      logic       evicted_valid;
      logic [3:0] evicted_handle;
   } pool_result_type;

   fbpm_pkg::frame_state_type frame_st[Frames];
   logic [3:0]      frame_holder[Frames];
   logic [2:0]      free_fifo[$];
   logic [2:0]      freeable_fifo[$];
   logic            bound[Handles];
   logic [2:0]      bound_frame[Handles];
   int              locks[Handles];
   pool_result_type expected_results[$];

   function automatic void remove_freeable(logic [2:0] f);
      for (int i = freeable_fifo.size() - 1; i >= 0; i--) begin
         if (freeable_fifo[i] == f) freeable_fifo.delete(i);
      end
   endfunction

   function automatic pool_result_type apply_command(logic [2:0] cmd, logic [3:0] h);
      pool_result_type r;
      fbpm_pkg::status_type status;
      logic [2:0] f;
      logic [2:0] nf;
      logic [3:0] old;
      fbpm_pkg::frame_state_type st;
      r = '0;
      status = fbpm_pkg::STATUS_OK;
      f = bound_frame[h];
      st = bound[h] ? frame_st[f] : fbpm_pkg::FRAME_FREE;
      case (cmd)
         fbpm_pkg::CMD_ACQUIRE: begin
            if (bound[h]) begin
               if (locks[h] == 0) begin
                  if (st == fbpm_pkg::FRAME_FREEABLE) begin
                     remove_freeable(f);
                     frame_st[f] = fbpm_pkg::FRAME_RENDERED;
                     locks[h] = 1;
                  end else begin
                     status = fbpm_pkg::STATUS_MISUSE;
                  end
               end else if (locks[h] >= MaxLock) begin
                  status = fbpm_pkg::STATUS_MISUSE;
               end else begin
                  locks[h]++;
               end
            end else if (free_fifo.size() == 0 && freeable_fifo.size() == 0) begin
               status = fbpm_pkg::STATUS_NONE;
            end else begin
               if (free_fifo.size() > 0) begin
                  nf = free_fifo.pop_front();
               end else begin
                  nf = freeable_fifo.pop_front();
                  remove_freeable(nf);
                  old = frame_holder[nf];
                  bound[old] = 1'b0;
                  locks[old] = 0;
                  r.evicted_valid = 1'b1;
                  r.evicted_handle = old;
               end
               frame_st[nf] = fbpm_pkg::FRAME_LOCKED;
               frame_holder[nf] = h;
               bound[h] = 1'b1;
               bound_frame[h] = nf;
               locks[h] = 1;
            end
         end
         fbpm_pkg::CMD_ACQUIRE_RENDERED: begin
            if (!bound[h]) begin
               status = fbpm_pkg::STATUS_NOT_RENDERED;
            end else if (locks[h] == 0) begin
               if (st == fbpm_pkg::FRAME_FREEABLE) begin
                  remove_freeable(f);
                  frame_st[f] = fbpm_pkg::FRAME_RENDERED;
                  locks[h] = 1;
               end else begin
                  status = fbpm_pkg::STATUS_MISUSE;
               end
            end else if (st == fbpm_pkg::FRAME_RENDERED) begin
               if (locks[h] >= MaxLock) status = fbpm_pkg::STATUS_MISUSE;
               else locks[h]++;
            end else begin
               status = fbpm_pkg::STATUS_NOT_RENDERED;
            end
         end
         fbpm_pkg::CMD_RELEASE: begin
            if (!bound[h] || locks[h] == 0) begin
               status = fbpm_pkg::STATUS_MISUSE;
            end else if (locks[h] > 1) begin
               locks[h]--;
            end else if (st == fbpm_pkg::FRAME_RENDERED) begin
               locks[h] = 0;
               frame_st[f] = fbpm_pkg::FRAME_FREEABLE;
               freeable_fifo.push_back(f);
            end else if (st == fbpm_pkg::FRAME_LOCKED) begin
               locks[h] = 0;
               frame_st[f] = fbpm_pkg::FRAME_FREE;
               bound[h] = 1'b0;
               free_fifo.push_back(f);
            end else begin
               status = fbpm_pkg::STATUS_MISUSE;
            end
         end
         fbpm_pkg::CMD_MARK_RENDERED: begin
            if (bound[h] && st == fbpm_pkg::FRAME_LOCKED) begin
               frame_st[f] = fbpm_pkg::FRAME_RENDERED;
            end else begin
               status = fbpm_pkg::STATUS_MISUSE;
            end
         end
         fbpm_pkg::CMD_QUERY: begin
            status = (bound[h] && st == fbpm_pkg::FRAME_RENDERED) ?
                     fbpm_pkg::STATUS_OK : fbpm_pkg::STATUS_NOT_RENDERED;
         end
         default: status = fbpm_pkg::STATUS_MISUSE;
      endcase
      r.status = status;
      if (bound[h]) begin
         r.frame_id = bound_frame[h];
         r.has_frame = 1'b1;
         r.frame_state = frame_st[bound_frame[h]];
      end
      r.lock_count = locks[h][7:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d", field, got, want);
      failures++;
   endtask

   always @(posedge clock) begin
      pool_result_type want;
      if (reset) begin
         for (int i = 0; i < Frames; i++) begin
            frame_st[i] = fbpm_pkg::FRAME_FREE;
            frame_holder[i] = '0;
         end
         for (int i = 0; i < Handles; i++) begin
            bound[i] = 1'b0;
            bound_frame[i] = '0;
            locks[i] = 0;
         end
         free_fifo.delete();
         freeable_fifo.delete();
         for (int i = 0; i < Frames; i++) free_fifo.push_back(i[2:0]);
         expected_results.delete();
         failures = 0;
         checked = 0;
         evictions = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = expected_results.pop_front();
               checked++;
               if (rsp_status != want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_frame_id != want.frame_id)
                  report_mismatch("frame_id", rsp_frame_id, want.frame_id);
               if (rsp_has_frame != want.has_frame)
                  report_mismatch("has_frame", rsp_has_frame, want.has_frame);
               if (rsp_frame_state != want.frame_state)
                  report_mismatch("frame_state", rsp_frame_state, want.frame_state);
               if (rsp_lock_count != want.lock_count)
                  report_mismatch("lock_count", rsp_lock_count, want.lock_count);
               if (rsp_evicted_valid != want.evicted_valid)
                  report_mismatch("evicted_valid", rsp_evicted_valid, want.evicted_valid);
               if (rsp_evicted_handle != want.evicted_handle)
                  report_mismatch("evicted_handle", rsp_evicted_handle, want.evicted_handle);
            end
         end
         if (req_valid && req_ready) begin
            want = apply_command(req_command, req_handle_id);
            if (want.evicted_valid) evictions++;
            expected_results.push_back(want);
         end
      end
      pending = expected_results.size();
   end

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random command transactions into the frame buffer
// pool manager with random idling on both channels and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int WatchdogLimit = 4000;
   localparam int RandomItems   = 1300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_command = '0;
   logic [3:0] req_handle_id = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [2:0] rsp_frame_id;
   logic       rsp_has_frame;
   logic [1:0] rsp_frame_state;
   logic [7:0] rsp_lock_count;
   logic       rsp_evicted_valid;
   logic [3:0] rsp_evicted_handle;

   int  failures;
   int  pending;
   int  checked;
   int  evictions;
   int  sent = 0;
   int  idle_cycles = 0;
   bit  idling_on = 1'b0;
   bit  hold_request = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   frame_buffer_pool_manager_core u_top (.*);

   fbpm_checker u_checker (.*);

   task automatic send_command(logic [2:0] cmd, logic [3:0] h);
      int gap;
      req_command <= cmd;
      req_handle_id <= h;
      req_valid <= 1'b1;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      sent++;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         rsp_ready <= 1'b0;
      end else if (idle_cycles > 0) begin
         idle_cycles <= idle_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         idle_cycles <= $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet = 0;
         else quiet++;
         if (quiet >= WatchdogLimit) begin
            $display("Timeout: no transaction for %0d cycles", WatchdogLimit);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      logic [3:0] h;
      int kind;
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_command(fbpm_pkg::CMD_ACQUIRE, 4'd0);
      send_command(fbpm_pkg::CMD_QUERY, 4'd0);
      send_command(fbpm_pkg::CMD_ACQUIRE_RENDERED, 4'd0);
      send_command(fbpm_pkg::CMD_MARK_RENDERED, 4'd0);
      send_command(fbpm_pkg::CMD_MARK_RENDERED, 4'd0);
      send_command(fbpm_pkg::CMD_QUERY, 4'd0);
      send_command(fbpm_pkg::CMD_ACQUIRE_RENDERED, 4'd0);
      send_command(fbpm_pkg::CMD_RELEASE, 4'd0);
      send_command(fbpm_pkg::CMD_RELEASE, 4'd0);
      send_command(fbpm_pkg::CMD_RELEASE, 4'd0);
      send_command(fbpm_pkg::CMD_ACQUIRE_RENDERED, 4'd0);
      send_command(fbpm_pkg::CMD_RELEASE, 4'd0);
      send_command(3'd5, 4'd15);
      send_command(3'd6, 4'd3);
      send_command(3'd7, 4'd0);
      send_command(fbpm_pkg::CMD_MARK_RENDERED, 4'd3);
      send_command(fbpm_pkg::CMD_RELEASE, 4'd3);
      send_command(fbpm_pkg::CMD_ACQUIRE_RENDERED, 4'd3);
      for (int i = 1; i <= 7; i++) send_command(fbpm_pkg::CMD_ACQUIRE, i[3:0]);
      send_command(fbpm_pkg::CMD_ACQUIRE, 4'd15);
      send_command(fbpm_pkg::CMD_ACQUIRE, 4'd9);

      idling_on = 1'b1;
      while (sent < RandomItems) begin
         if (sent > RandomItems - 200) idling_on = 1'b0;
         h = 4'($urandom_range(0, 15));
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            send_command(fbpm_pkg::CMD_ACQUIRE, h);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) send_command(fbpm_pkg::CMD_ACQUIRE, h);
            if ($urandom_range(0, 2) != 0) send_command(fbpm_pkg::CMD_MARK_RENDERED, h);
            if ($urandom_range(0, 1)) send_command(fbpm_pkg::CMD_ACQUIRE_RENDERED, h);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) send_command(fbpm_pkg::CMD_RELEASE, h);
            if ($urandom_range(0, 3) == 0) send_command(fbpm_pkg::CMD_QUERY, h);
         end else if (kind < 9) begin
            send_command(3'($urandom_range(0, 4)), h);
         end else begin
            send_command(3'($urandom_range(0, 7)), h);
         end
         if (sent > 400 && sent < 420) begin
            hold_request = 1'b1;
            fork
               begin
                  repeat (300) @(posedge clock);
                  hold_request = 1'b0;
               end
               begin
                  for (int i = 0; i < 4; i++) send_command(fbpm_pkg::CMD_QUERY, h);
               end
            join
            for (int i = 0; i < 258; i++) send_command(fbpm_pkg::CMD_ACQUIRE, h);
            for (int i = 0; i < 258; i++) send_command(fbpm_pkg::CMD_ACQUIRE_RENDERED, h);
            for (int i = 0; i < 256; i++) send_command(fbpm_pkg::CMD_RELEASE, h);
         end
      end
      @(posedge clock);
      req_valid <= 1'b0;

      n = 0;
      while (pending != 0 && n < 2000) begin
         @(posedge clock);
         n++;
      end
      repeat (30) @(posedge clock);
      $display("Sent %0d commands; checked %0d responses, %0d with a reclaimed frame.",
               sent, checked, evictions);
      $display("Coverage included lock overflow, misuse cases and a long response stall.");
      if (failures == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
